/* src/lssp_pkg.sv */
// Shared types and constants of the limit sweep speed profiler.
package lssp_pkg;

	localparam int unsigned TICK_W  = 13;
	localparam int unsigned SPEED_W = 15;
	localparam int unsigned POS_W   = 16;

	localparam logic [TICK_W-1:0]  STARTUP_TICKS = 13'd5200;
	localparam logic [SPEED_W-1:0] SPEED_FLOOR   = 15'd2000;
	localparam logic [SPEED_W-1:0] RESET_SPEED   = 15'd4000;
	localparam logic signed [POS_W+1:0] RAMP_ZONE = 18'sd1000;

	localparam logic signed [POS_W-1:0] RESET_LEFT_BOUND  = -16'sd20000;
	localparam logic signed [POS_W-1:0] RESET_RIGHT_BOUND = 16'sd20000;
	localparam logic [SPEED_W-1:0]      RESET_MAX_SPEED   = 15'd4000;

	localparam logic [1:0] REG_LEFT_BOUND  = 2'd0;
	localparam logic [1:0] REG_RIGHT_BOUND = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED   = 2'd2;

	localparam logic [1:0] HOME_WAIT   = 2'd0;
	localparam logic [1:0] HOME_RELOAD = 2'd1;
	localparam logic [1:0] HOME_DONE   = 2'd2;

	typedef struct packed {
		logic signed [POS_W-1:0] left_bound;
		logic signed [POS_W-1:0] right_bound;
		logic [SPEED_W-1:0]      max_speed;
	} cfg_t;

	typedef struct packed {
		logic               running;
		logic [TICK_W-1:0]  ticks;
		logic               sweep_left;
		logic               polarity;
		logic [SPEED_W-1:0] speed;
		logic [1:0]         home;
		logic               indicator;
	} state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] left_drive;
		logic signed [POS_W-1:0] right_drive;
		logic                    reload_counter;
		logic                    led_on;
		logic                    moving_left;
		logic                    running;
	} result_t;

endpackage

/* src/lssp_step.sv */
// Next-state and result logic for one control tick of the speed profiler.
module lssp_step (
	input  lssp_pkg::cfg_t                   cfg,
	input  lssp_pkg::state_t                 cur,
	input  logic signed [lssp_pkg::POS_W-1:0] position,
	input  logic                             home_switch,
	input  logic                             enable,
	output lssp_pkg::state_t                 nxt,
	output lssp_pkg::result_t                res
);

	logic signed [lssp_pkg::POS_W+1:0] pos_x;
	logic signed [lssp_pkg::POS_W+1:0] left_zone;
	logic signed [lssp_pkg::POS_W+1:0] right_zone;
	logic signed [lssp_pkg::POS_W+1:0] left_x;
	logic signed [lssp_pkg::POS_W+1:0] right_x;
	logic signed [lssp_pkg::SPEED_W+1:0] dec_sum;
	logic [lssp_pkg::SPEED_W:0]   inc_sum;
	logic [lssp_pkg::SPEED_W-1:0] speed_dec;
	logic [lssp_pkg::SPEED_W-1:0] speed_inc;
	logic in_left_zone;
	logic in_right_zone;
	logic [lssp_pkg::TICK_W-1:0] ticks_inc;
	logic signed [lssp_pkg::POS_W-1:0] spd;
	logic signed [lssp_pkg::POS_W-1:0] drive_l;
	logic signed [lssp_pkg::POS_W-1:0] drive_r;
	logic reload;

	assign pos_x      = {{2{position[lssp_pkg::POS_W-1]}}, position};
	assign left_x     = {{2{cfg.left_bound[lssp_pkg::POS_W-1]}}, cfg.left_bound};
	assign right_x    = {{2{cfg.right_bound[lssp_pkg::POS_W-1]}}, cfg.right_bound};
	assign left_zone  = left_x + lssp_pkg::RAMP_ZONE;
	assign right_zone = right_x - lssp_pkg::RAMP_ZONE;
	assign in_left_zone  = pos_x < left_zone;
	assign in_right_zone = pos_x > right_zone;

	assign dec_sum   = $signed({2'b00, cur.speed}) - 17'sd4;
	assign speed_dec = (dec_sum <= $signed({2'b00, lssp_pkg::SPEED_FLOOR})) ?
		lssp_pkg::SPEED_FLOOR : dec_sum[lssp_pkg::SPEED_W-1:0];
	assign inc_sum   = {1'b0, cur.speed} + 16'd3;
	assign speed_inc = (inc_sum >= {1'b0, cfg.max_speed}) ?
		cfg.max_speed : inc_sum[lssp_pkg::SPEED_W-1:0];

	assign ticks_inc = cur.ticks + 13'd1;
	assign spd       = $signed({1'b0, cur.speed});

	always_comb begin
		nxt    = cur;
		reload = 1'b0;
		case (cur.home)
			lssp_pkg::HOME_WAIT: begin
				if (home_switch) begin
					nxt.home      = lssp_pkg::HOME_RELOAD;
					nxt.indicator = 1'b1;
				end
			end
			lssp_pkg::HOME_RELOAD: begin
				reload   = 1'b1;
				nxt.home = lssp_pkg::HOME_DONE;
			end
			default: ;
		endcase

		if (!cur.running) begin
			nxt.ticks = ticks_inc;
			if (ticks_inc == lssp_pkg::STARTUP_TICKS) begin
				nxt.ticks      = '0;
				nxt.running    = 1'b1;
				nxt.sweep_left = 1'b1;
				nxt.polarity   = position[lssp_pkg::POS_W-1];
				nxt.indicator  = 1'b1;
			end
		end else begin
			nxt.indicator = 1'b0;
			if (cur.sweep_left) begin
				if (pos_x <= left_x) begin
					nxt.sweep_left = 1'b0;
					nxt.home       = lssp_pkg::HOME_WAIT;
				end
				if (in_left_zone) begin
					nxt.speed = speed_dec;
				end else if (in_right_zone) begin
					nxt.speed = speed_inc;
				end
			end else begin
				if (pos_x >= right_x) begin
					nxt.sweep_left = 1'b1;
					nxt.home       = lssp_pkg::HOME_WAIT;
				end
				if (in_left_zone) begin
					nxt.speed = speed_inc;
				end else if (in_right_zone) begin
					nxt.speed = speed_dec;
				end
			end
		end

		if (!nxt.running || (nxt.polarity == nxt.sweep_left)) begin
			drive_l = $signed({1'b0, nxt.speed});
			drive_r = -$signed({1'b0, nxt.speed});
		end else begin
			drive_l = -$signed({1'b0, nxt.speed});
			drive_r = $signed({1'b0, nxt.speed});
		end
		if (!cur.running) begin
			drive_l = spd;
			drive_r = -spd;
		end
		if (!enable) begin
			drive_l = '0;
			drive_r = '0;
		end

		res.left_drive     = drive_l;
		res.right_drive    = drive_r;
		res.reload_counter = reload;
		res.led_on         = nxt.indicator;
		res.moving_left    = nxt.sweep_left;
		res.running        = nxt.running;
	end

endmodule

/* src/limit_sweep_speed_profiler_core.sv */
// Top level of the limit sweep speed profiler: handshakes, registers and state.
//
//  channel | direction | payload
//  s_*     | in        | s_tdata: position, home_switch, enable
//  m_*     | out       | m_tdata: left_drive, right_drive, reload_counter, led_on,
//          |           |          moving_left, running
//  cfg_*   | in        | cfg_index, cfg_data (register write, always ready)
//
// One request per cycle while m_tready holds; each passes through the input register,
// then the step logic into the result register.
// Reset clears the state (speed to RESET_SPEED) and loads the register defaults; no clearing pass.
// A stalled result holds in the output register while one more request waits
// in the input register.
module limit_sweep_speed_profiler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // position[15:0], home_switch[16], enable[17], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // left_drive[15:0], right_drive[31:16],
	                               // reload_counter[32], led_on[33], moving_left[34],
	                               // running[35], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	lssp_pkg::cfg_t    cfg_q;
	lssp_pkg::state_t  state_q;
	lssp_pkg::state_t  state_nxt;
	lssp_pkg::result_t res_nxt;
	lssp_pkg::result_t res_q;

	logic                              valid_s1;
	logic signed [lssp_pkg::POS_W-1:0] pos_s1;
	logic                              sw_s1;
	logic                              en_s1;
	logic                              out_valid_q;
	logic                              advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {4'b0000, res_q.running, res_q.moving_left, res_q.led_on,
		res_q.reload_counter, res_q.right_drive, res_q.left_drive};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_bound  <= lssp_pkg::RESET_LEFT_BOUND;
			cfg_q.right_bound <= lssp_pkg::RESET_RIGHT_BOUND;
			cfg_q.max_speed   <= lssp_pkg::RESET_MAX_SPEED;
		end else if (cfg_valid) begin
			case (cfg_index)
				lssp_pkg::REG_LEFT_BOUND:  cfg_q.left_bound  <= cfg_data;
				lssp_pkg::REG_RIGHT_BOUND: cfg_q.right_bound <= cfg_data;
				lssp_pkg::REG_MAX_SPEED:   cfg_q.max_speed   <= cfg_data[lssp_pkg::SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pos_s1 <= s_tdata[15:0];
			sw_s1  <= s_tdata[16];
			en_s1  <= s_tdata[17];
		end
	end

	lssp_step u_step (
		.cfg         (cfg_q),
		.cur         (state_q),
		.position    (pos_s1),
		.home_switch (sw_s1),
		.enable      (en_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.running    <= 1'b0;
			state_q.ticks      <= '0;
			state_q.sweep_left <= 1'b0;
			state_q.polarity   <= 1'b0;
			state_q.speed      <= lssp_pkg::RESET_SPEED;
			state_q.home       <= lssp_pkg::HOME_WAIT;
			state_q.indicator  <= 1'b0;
			out_valid_q        <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_running_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.running |=> state_q.running)
		else $error("run phase left");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a request");

	a_reload_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.home == lssp_pkg::HOME_RELOAD) |=> res_q.reload_counter)
		else $error("reload not requested");

	a_drives_opposed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((res_q.left_drive + res_q.right_drive) == 16'sd0))
		else $error("drives not opposed");
`endif

endmodule

/* tb/sv/tb_limit_sweep_speed_profiler_core.sv */
// Self-checking testbench of the limit sweep speed profiler core with a tick-by-tick result predictor.
module tb_limit_sweep_speed_profiler_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_CYCLES = 2;
	localparam int ZONE        = 1000;
	localparam int FLOOR       = 2000;
	localparam int NROWS       = 18;
	localparam int NSETUPS     = 5;
	localparam int NPHASES     = 8;
	localparam int PHASE_TICKS = 205;

	typedef struct packed {
		logic signed [lssp_pkg::POS_W-1:0] pos;
		logic                              sw;
		logic                              en;
		logic                              latch;
		logic                              typed;
		lssp_pkg::result_t                 res;
	} row_t;

	localparam lssp_pkg::result_t NONE = '0;

	localparam row_t TICK_PLAN [NROWS] = '{
		'{16'sd0,      1'b0, 1'b1, 1'b0, 1'b1, '{16'sd4000, -16'sd4000, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{16'sd0,      1'b0, 1'b0, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{16'sd32767,  1'b1, 1'b1, 1'b0, 1'b1, '{16'sd4000, -16'sd4000, 1'b0, 1'b1, 1'b0, 1'b0}},
		'{-16'sd32768, 1'b0, 1'b1, 1'b0, 1'b1, '{16'sd4000, -16'sd4000, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{16'sd1,      1'b1, 1'b1, 1'b0, 1'b1, '{16'sd4000, -16'sd4000, 1'b0, 1'b1, 1'b0, 1'b0}},
		'{-16'sd1,     1'b0, 1'b0, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0, 1'b0}},
		'{-16'sd5,     1'b0, 1'b1, 1'b1, 1'b0, NONE},
		'{16'sd0,      1'b0, 1'b1, 1'b0, 1'b0, NONE},
		'{16'sd19500,  1'b0, 1'b1, 1'b0, 1'b0, NONE},
		'{-16'sd19500, 1'b0, 1'b1, 1'b0, 1'b0, NONE},
		'{-16'sd32768, 1'b0, 1'b1, 1'b0, 1'b0, NONE},
		'{-16'sd32768, 1'b1, 1'b1, 1'b0, 1'b0, NONE},
		'{16'sd32767,  1'b0, 1'b1, 1'b0, 1'b0, NONE},
		'{16'sd20000,  1'b0, 1'b0, 1'b0, 1'b0, NONE},
		'{-16'sd20000, 1'b1, 1'b1, 1'b0, 1'b0, NONE},
		'{16'sd20000,  1'b0, 1'b1, 1'b0, 1'b0, NONE},
		'{16'sd19000,  1'b0, 1'b1, 1'b0, 1'b0, NONE},
		'{16'sd19001,  1'b0, 1'b1, 1'b0, 1'b0, NONE}
	};

	localparam lssp_pkg::cfg_t SETUPS [NSETUPS] = '{
		'{-16'sd600,   16'sd600,    15'd1500},
		'{-16'sd32768, 16'sd32767,  15'd32767},
		'{-16'sd600,   16'sd600,    15'd0},
		'{16'sd32767,  -16'sd32768, 15'd2000},
		'{-16'sd1500,  16'sd1500,   15'd2600}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = lssp_pkg::REG_LEFT_BOUND;
	logic [15:0] cfg_data = '0;

	logic                        run_ph = 1'b0;
	logic [lssp_pkg::TICK_W-1:0] tick_cnt = '0;
	logic                        going_left = 1'b0;
	logic                        polar = 1'b0;
	int                          speed_now = 4000;
	logic [1:0]                  home_st = lssp_pkg::HOME_WAIT;
	logic                        lamp = 1'b0;
	int                          lim_left = -20000;
	int                          lim_right = 20000;
	int                          top_speed = 4000;

	lssp_pkg::result_t drive_q [$];
	int      n_mismatch = 0;
	logic    steady = 1'b0;
	int      trk = 0;
	logic    rdy_on = 1'b0;
	int      rdy_run = 0;

	limit_sweep_speed_profiler_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int ramp_down(input int s);
		return (s - 4 <= FLOOR) ? FLOOR : s - 4;
	endfunction

	function automatic int ramp_up(input int s);
		return (s + 3 >= top_speed) ? top_speed : s + 3;
	endfunction

	function automatic lssp_pkg::result_t step_profile(
			input logic signed [lssp_pkg::POS_W-1:0] pos, input logic sw, input logic en);
		lssp_pkg::result_t r;
		int      p;
		int      drv;
		logic    rel;
		p = pos;
		rel = 1'b0;
		case (home_st)
			lssp_pkg::HOME_WAIT: begin
				if (sw) begin
					home_st = lssp_pkg::HOME_RELOAD;
					lamp = 1'b1;
				end
			end
			lssp_pkg::HOME_RELOAD: begin
				rel = 1'b1;
				home_st = lssp_pkg::HOME_DONE;
			end
			default: ;
		endcase
		if (!run_ph) begin
			drv = speed_now;
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt == lssp_pkg::STARTUP_TICKS) begin
				tick_cnt = '0;
				run_ph = 1'b1;
				going_left = 1'b1;
				polar = (p < 0);
				lamp = 1'b1;
			end
		end else begin
			lamp = 1'b0;
			if (going_left) begin
				if (p <= lim_left) begin
					going_left = 1'b0;
					home_st = lssp_pkg::HOME_WAIT;
				end
				if (p < lim_left + ZONE) speed_now = ramp_down(speed_now);
				else if (p > lim_right - ZONE) speed_now = ramp_up(speed_now);
			end else begin
				if (p >= lim_right) begin
					going_left = 1'b1;
					home_st = lssp_pkg::HOME_WAIT;
				end
				if (p < lim_left + ZONE) speed_now = ramp_up(speed_now);
				else if (p > lim_right - ZONE) speed_now = ramp_down(speed_now);
			end
			drv = (polar == going_left) ? speed_now : -speed_now;
		end
		if (!en) drv = 0;
		r.left_drive = 16'(drv);
		r.right_drive = 16'(-drv);
		r.reload_counter = rel;
		r.led_on = lamp;
		r.moving_left = going_left;
		r.running = run_ph;
		return r;
	endfunction

	task automatic send_tick(input logic signed [lssp_pkg::POS_W-1:0] pos, input logic sw,
			input logic en, input logic typed, input lssp_pkg::result_t typed_res);
		lssp_pkg::result_t want;
		want = step_profile(pos, sw, en);
		drive_q.push_back(typed ? typed_res : want);
		s_tdata <= {6'b0, en, sw, pos};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (!steady && $urandom_range(0, 9) < 3) begin
			s_tvalid <= 1'b0;
			repeat (($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	task automatic random_tick();
		send_tick(16'($urandom), $urandom_range(0, 15) == 0, $urandom_range(0, 9) != 0, 1'b0, NONE);
	endtask

	task automatic sweep_tick();
		int stp;
		logic signed [lssp_pkg::POS_W-1:0] pos;
		stp = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 60) : $urandom_range(50, 600);
		trk = going_left ? trk - stp : trk + stp;
		if (trk < -32768) trk = -32768;
		if (trk > 32767) trk = 32767;
		pos = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(trk);
		send_tick(pos, $urandom_range(0, 15) == 0, $urandom_range(0, 9) != 0, 1'b0, NONE);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES + 2) @(posedge clk);
	endtask

	task automatic write_setup(input lssp_pkg::cfg_t c);
		logic [1:0]  idx [3];
		logic [15:0] val [3];
		idx = '{lssp_pkg::REG_LEFT_BOUND, lssp_pkg::REG_RIGHT_BOUND, lssp_pkg::REG_MAX_SPEED};
		val = '{c.left_bound, c.right_bound, {1'b0, c.max_speed}};
		for (int i = 0; i < 3; i++) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		lim_left = int'(c.left_bound);
		lim_right = int'(c.right_bound);
		top_speed = int'(c.max_speed);
	endtask

	always @(posedge clk) begin
		lssp_pkg::result_t got;
		lssp_pkg::result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.left_drive = m_tdata[15:0];
				got.right_drive = m_tdata[31:16];
				got.reload_counter = m_tdata[32];
				got.led_on = m_tdata[33];
				got.moving_left = m_tdata[34];
				got.running = m_tdata[35];
				if (drive_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected result: L=%0d R=%0d", got.left_drive, got.right_drive);
				end else begin
					want = drive_q.pop_front();
					if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive
							|| got.reload_counter !== want.reload_counter
							|| got.led_on !== want.led_on || got.moving_left !== want.moving_left
							|| got.running !== want.running) begin
						n_mismatch++;
						if (n_mismatch <= 10) begin
							$display("mismatch: expected L=%0d R=%0d rl=%b led=%b ml=%b run=%b",
								want.left_drive, want.right_drive, want.reload_counter,
								want.led_on, want.moving_left, want.running);
							$display("          actual   L=%0d R=%0d rl=%b led=%b ml=%b run=%b",
								got.left_drive, got.right_drive, got.reload_counter,
								got.led_on, got.moving_left, got.running);
						end
					end
				end
			end
			if (rdy_run == 0) begin
				rdy_on = steady || ($urandom_range(0, 3) != 0);
				if (rdy_on) rdy_run = $urandom_range(1, 30);
				else rdy_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
					: $urandom_range(1, 3);
			end
			rdy_run--;
			m_tready <= rdy_on;
		end
	end

	initial begin
		row_t rw;
		lssp_pkg::cfg_t c;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int k = 0; k < NROWS; k++) begin
			rw = TICK_PLAN[k];
			if (rw.latch) begin
				while (tick_cnt != lssp_pkg::STARTUP_TICKS - 1'b1) random_tick();
			end
			send_tick(rw.pos, rw.sw, rw.en, rw.typed, rw.res);
		end
		for (int ph = 0; ph < NPHASES; ph++) begin
			drain();
			if (ph < NSETUPS) begin
				c = SETUPS[ph];
			end else begin
				c.left_bound = 16'($urandom);
				c.right_bound = 16'($urandom);
				c.max_speed = 15'($urandom);
			end
			write_setup(c);
			steady = ($urandom_range(0, 3) == 0);
			repeat (PHASE_TICKS) sweep_tick();
		end
		drain();
		if (n_mismatch == 0 && drive_q.size() == 0) begin
			$display("tb_limit_sweep_speed_profiler_core passed");
		end else begin
			$display("tb_limit_sweep_speed_profiler_core failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb_limit_sweep_speed_profiler_core failed");
		$finish;
	end

endmodule
